>>> rtl/core/yuvacc_pkg.sv
// ----------------------------------------------------------------------------
// yuvacc_pkg
// Shared types, constants and helpers of the YUV 4:2:2 to RGB accumulate core.
// ----------------------------------------------------------------------------
package yuvacc_pkg;

  // sum store geometry
  localparam int MAX_PIXELS = 131072;
  localparam int SUM_WIDTH  = 32;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CLR_W      = ADDR_W + 1;

  // pixel position and result widths
  localparam int POS_W     = 22;
  localparam int INDEX_W   = 17;
  localparam int OUT_SUM_W = 32;

  // configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

  localparam logic [CFG_W-1:0] DEF_WIDTH  = 12'd320;
  localparam logic [CFG_W-1:0] DEF_HEIGHT = 12'd240;
  localparam logic [POS_W:0]   POS_SPAN   = {1'b1, {POS_W{1'b0}}};
  localparam logic [POS_W:0]   FRAME_SIZE_RST = (POS_W+1)'(320 * 240);

  // color arithmetic
  localparam int CW = 19;
  localparam logic signed [CW-1:0] COEF_RV = 19'sd359;
  localparam logic signed [CW-1:0] COEF_GU = 19'sd88;
  localparam logic signed [CW-1:0] COEF_GV = 19'sd183;
  localparam logic signed [CW-1:0] COEF_BU = 19'sd454;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
    logic             drop;
    logic             second;
  } info_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cu;     // U - 128, two's complement
    logic [7:0] cv;     // V - 128, two's complement
    info_t      info;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    info_t      info;
  } col_t;

  typedef struct packed {
    logic [INDEX_W-1:0]   pixel_index;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [OUT_SUM_W-1:0] sum_red;
    logic [OUT_SUM_W-1:0] sum_green;
    logic [OUT_SUM_W-1:0] sum_blue;
    logic                 end_of_frame;
    logic                 dropped;
    logic                 last_of_pair;
  } res_t;

  // floor shift by 8, clip to 0..255
  function automatic logic [7:0] clip_color(input logic signed [CW-1:0] val);
    logic [7:0] c;
    if (val[CW-1]) begin
      c = 8'h00;
    end else if (val[CW-2:16] != '0) begin
      c = 8'hFF;
    end else begin
      c = val[15:8];
    end
    return c;
  endfunction

  // low result bits of a store entry
  function automatic logic [OUT_SUM_W-1:0] sum_to_out(input logic [SUM_WIDTH-1:0] s);
    logic [63:0] t;
    t = 64'(s);
    return t[OUT_SUM_W-1:0];
  endfunction

endpackage

>>> rtl/core/yuvacc_ram.sv
// ----------------------------------------------------------------------------
// yuvacc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module yuvacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/yuvacc_seq.sv
// ----------------------------------------------------------------------------
// yuvacc_seq
// Macropixel input register, pixel splitter and raster position counter.
// ----------------------------------------------------------------------------
module yuvacc_seq
  import yuvacc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             clearing,
  input  logic             palette_mode,
  input  logic [CFG_W-1:0] frame_width,
  input  logic [CFG_W-1:0] frame_height,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  logic [7:0]       byte_zero,
  input  logic [7:0]       byte_one,
  input  logic [7:0]       byte_two,
  input  logic [7:0]       byte_three,
  input  logic             frame_start,
  output logic             s1_valid,
  output pix_t             s1
);

  logic             s0_valid;
  logic             s0_half;
  logic [7:0]       s0_y0;
  logic [7:0]       s0_y1;
  logic [7:0]       s0_u;
  logic [7:0]       s0_v;
  logic             s0_fs;
  logic [POS_W-1:0] pos;
  logic [POS_W:0]   frame_size;

  logic [2*CFG_W-1:0] frame_prod;
  logic [POS_W:0]     frame_size_next;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W:0]     pos_inc;
  logic               last;
  logic               drop;
  logic               emit;
  logic               accept;
  pix_t               s1_next;

  assign frame_prod      = frame_width * frame_height;
  assign frame_size_next = (frame_prod > (2*CFG_W)'(POS_SPAN)) ? POS_SPAN
                                                               : frame_prod[POS_W:0];

  assign emit      = s0_valid && advance;
  assign pix_ready = !clearing && (!s0_valid || (advance && s0_half));
  assign accept    = pix_valid && pix_ready;

  // frame start only restarts the position before the first pixel of a word
  assign pos_cur = (!s0_half && s0_fs) ? '0 : pos;
  assign pos_inc = {1'b0, pos_cur} + (POS_W+1)'(1);
  assign last    = (pos_inc >= frame_size);
  assign drop    = ({1'b0, pos_cur} >= (POS_W+1)'(MAX_PIXELS));

  always_comb begin
    s1_next.luma        = s0_half ? s0_y1 : s0_y0;
    s1_next.cu          = {~s0_u[7], s0_u[6:0]};
    s1_next.cv          = {~s0_v[7], s0_v[6:0]};
    s1_next.info.pos    = pos_cur;
    s1_next.info.last   = last;
    s1_next.info.drop   = drop;
    s1_next.info.second = s0_half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      s0_half    <= 1'b0;
      pos        <= '0;
      frame_size <= FRAME_SIZE_RST;
      s1_valid   <= 1'b0;
    end else begin
      frame_size <= frame_size_next;
      if (advance) begin
        s1_valid <= s0_valid;
      end
      if (emit) begin
        pos <= last ? '0 : pos_inc[POS_W-1:0];
      end
      if (accept) begin
        s0_valid <= 1'b1;
        s0_half  <= 1'b0;
      end else if (emit) begin
        s0_half <= ~s0_half;
        if (s0_half) begin
          s0_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_fs <= frame_start;
      if (palette_mode) begin
        s0_u  <= byte_zero;
        s0_y0 <= byte_one;
        s0_v  <= byte_two;
        s0_y1 <= byte_three;
      end else begin
        s0_y0 <= byte_zero;
        s0_u  <= byte_one;
        s0_y1 <= byte_two;
        s0_v  <= byte_three;
      end
    end
    if (advance) begin
      s1 <= s1_next;
    end
  end

endmodule

>>> rtl/core/yuvacc_color.sv
// ----------------------------------------------------------------------------
// yuvacc_color
// Two-stage fixed-point color conversion: products, then sums and clipping.
// ----------------------------------------------------------------------------
module yuvacc_color
  import yuvacc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  s1_valid,
  input  pix_t  s1,
  output logic  s2_valid,
  output info_t s2_info,
  output logic  s3_valid,
  output col_t  s3
);

  logic signed [CW-1:0] cu_w;
  logic signed [CW-1:0] cv_w;
  logic signed [CW-1:0] p_rv_next;
  logic signed [CW-1:0] p_gu_next;
  logic signed [CW-1:0] p_gv_next;
  logic signed [CW-1:0] p_bu_next;

  logic [15:0]          ys;
  logic signed [CW-1:0] p_rv;
  logic signed [CW-1:0] p_gu;
  logic signed [CW-1:0] p_gv;
  logic signed [CW-1:0] p_bu;

  logic signed [CW-1:0] ys_s;
  logic signed [CW-1:0] r_val;
  logic signed [CW-1:0] g_val;
  logic signed [CW-1:0] b_val;
  col_t                 s3_next;

  assign cu_w = CW'($signed(s1.cu));
  assign cv_w = CW'($signed(s1.cv));

  assign p_rv_next = cv_w * COEF_RV;
  assign p_gu_next = cu_w * COEF_GU;
  assign p_gv_next = cv_w * COEF_GV;
  assign p_bu_next = cu_w * COEF_BU;

  assign ys_s  = $signed({{(CW-16){1'b0}}, ys});
  assign r_val = ys_s + p_rv;
  assign g_val = ys_s - p_gu - p_gv;
  assign b_val = ys_s + p_bu;

  always_comb begin
    s3_next.red   = clip_color(r_val);
    s3_next.green = clip_color(g_val);
    s3_next.blue  = clip_color(b_val);
    s3_next.info  = s2_info;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ys      <= {s1.luma, 8'h00};
      p_rv    <= p_rv_next;
      p_gu    <= p_gu_next;
      p_gv    <= p_gv_next;
      p_bu    <= p_bu_next;
      s2_info <= s1.info;
      s3      <= s3_next;
    end
  end

endmodule

>>> rtl/core/yuvacc_accum.sv
// ----------------------------------------------------------------------------
// yuvacc_accum
// Per-pixel RGB sum store: clearing pass, read-modify-write with forwarding,
// and the result register.
// ----------------------------------------------------------------------------
module yuvacc_accum
  import yuvacc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  s2_valid,
  input  info_t s2_info,
  input  logic  s3_valid,
  input  col_t  s3,
  output logic  clearing,
  output logic  res_valid,
  output res_t  res
);

  localparam int RAM_W = 3 * SUM_WIDTH;

  logic [CLR_W-1:0]     clear_cnt;
  logic                 fwd_hit;
  logic [RAM_W-1:0]     fwd_data;

  logic [RAM_W-1:0]     rdata;
  logic [RAM_W-1:0]     old_sum;
  logic [SUM_WIDTH-1:0] new_r;
  logic [SUM_WIDTH-1:0] new_g;
  logic [SUM_WIDTH-1:0] new_b;
  logic [RAM_W-1:0]     new_sum;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [RAM_W-1:0]     wdata;
  logic                 fwd_hit_next;
  res_t                 res_next;

  assign clearing = (clear_cnt != CLR_W'(MAX_PIXELS));

  // the word written this cycle is not yet visible to the read issued now
  assign old_sum = fwd_hit ? fwd_data : rdata;
  assign new_r   = old_sum[3*SUM_WIDTH-1:2*SUM_WIDTH] + SUM_WIDTH'(s3.red);
  assign new_g   = old_sum[2*SUM_WIDTH-1:SUM_WIDTH]   + SUM_WIDTH'(s3.green);
  assign new_b   = old_sum[SUM_WIDTH-1:0]             + SUM_WIDTH'(s3.blue);
  assign new_sum = {new_r, new_g, new_b};

  assign we    = clearing || (advance && s3_valid && !s3.info.drop);
  assign waddr = clearing ? clear_cnt[ADDR_W-1:0] : s3.info.pos[ADDR_W-1:0];
  assign wdata = clearing ? '0 : new_sum;

  assign fwd_hit_next = s2_valid && s3_valid && !s3.info.drop &&
                        (s2_info.pos == s3.info.pos);

  yuvacc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (advance),
    .raddr (s2_info.pos[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    res_next.pixel_index  = s3.info.pos[INDEX_W-1:0];
    res_next.red          = s3.red;
    res_next.green        = s3.green;
    res_next.blue         = s3.blue;
    res_next.sum_red      = s3.info.drop ? '0 : sum_to_out(new_r);
    res_next.sum_green    = s3.info.drop ? '0 : sum_to_out(new_g);
    res_next.sum_blue     = s3.info.drop ? '0 : sum_to_out(new_b);
    res_next.end_of_frame = s3.info.last;
    res_next.dropped      = s3.info.drop;
    res_next.last_of_pair = s3.info.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
      fwd_hit   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clear_cnt <= clear_cnt + CLR_W'(1);
      end
      if (advance) begin
        fwd_hit   <= fwd_hit_next;
        res_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_data <= new_sum;
      res      <= res_next;
    end
  end

endmodule

>>> rtl/core/yuyv_to_rgb_accumulate_core.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_accumulate_core
// Packed 4:2:2 to RGB conversion with per-pixel RGB accumulation.
// ----------------------------------------------------------------------------
// Each input word is one macropixel and yields two result words, first pixel
// first. The result port delivers one pixel per cycle while res_ready is high;
// the next word is taken as the second pixel of the last one leaves the input
// register, so the single result handshake sets the rate. A word passes s0,
// s1, s2, s3 and the result register. Each stored pixel has one RAM row with
// a read-modify-write. After reset a clearing pass zeroes all MAX_PIXELS
// (131072) rows with pix_ready low; configuration writes are taken during it.
module yuyv_to_rgb_accumulate_core
  import yuvacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  logic [7:0]           byte_zero,
  input  logic [7:0]           byte_one,
  input  logic [7:0]           byte_two,
  input  logic [7:0]           byte_three,
  input  logic                 frame_start,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [INDEX_W-1:0]   pixel_index,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic [OUT_SUM_W-1:0] sum_red,
  output logic [OUT_SUM_W-1:0] sum_green,
  output logic [OUT_SUM_W-1:0] sum_blue,
  output logic                 end_of_frame,
  output logic                 dropped,
  output logic                 last_of_pair,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic             palette_mode;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic  advance;
  logic  clearing;
  logic  s1_valid;
  pix_t  s1;
  logic  s2_valid;
  info_t s2_info;
  logic  s3_valid;
  col_t  s3;
  res_t  res;

  assign cfg_ready = 1'b1;
  // the whole pipeline moves unless a result word waits
  assign advance   = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_mode <= 1'b0;
      frame_width  <= DEF_WIDTH;
      frame_height <= DEF_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PALETTE: palette_mode <= cfg_data[0];
        REG_WIDTH:   frame_width  <= cfg_data;
        REG_HEIGHT:  frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  yuvacc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .clearing     (clearing),
    .palette_mode (palette_mode),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .byte_zero    (byte_zero),
    .byte_one     (byte_one),
    .byte_two     (byte_two),
    .byte_three   (byte_three),
    .frame_start  (frame_start),
    .s1_valid     (s1_valid),
    .s1           (s1)
  );

  yuvacc_color u_color (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_info  (s2_info),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  yuvacc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s2_valid  (s2_valid),
    .s2_info   (s2_info),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res)
  );

  assign pixel_index  = res.pixel_index;
  assign red          = res.red;
  assign green        = res.green;
  assign blue         = res.blue;
  assign sum_red      = res.sum_red;
  assign sum_green    = res.sum_green;
  assign sum_blue     = res.sum_blue;
  assign end_of_frame = res.end_of_frame;
  assign dropped      = res.dropped;
  assign last_of_pair = res.last_of_pair;

endmodule

>>> rtl/core/yuvacc_checker.sv
// ----------------------------------------------------------------------------
// yuvacc_checker
// Port-level assertions for the accumulate core, bound to the top level.
// ----------------------------------------------------------------------------
module yuvacc_checker
  import yuvacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_ready,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  logic [INDEX_W-1:0]   pixel_index,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic [OUT_SUM_W-1:0] sum_red,
  input  logic [OUT_SUM_W-1:0] sum_green,
  input  logic [OUT_SUM_W-1:0] sum_blue,
  input  logic                 end_of_frame,
  input  logic                 dropped,
  input  logic                 last_of_pair
);

  // hold a stalled result word
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pixel_index) &&
      $stable(red) && $stable(green) && $stable(blue) &&
      $stable(sum_red) && $stable(sum_green) && $stable(sum_blue) &&
      $stable(end_of_frame) && $stable(last_of_pair) && $stable(dropped))
    else $error("result word changed while stalled");

  // no result word right after reset
  a_rst_res: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // the clearing pass blocks input right after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !pix_ready)
    else $error("input taken during store clearing");

  // a dropped pixel adds nothing and reports zero sums
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && dropped |-> sum_red == '0 && sum_green == '0 && sum_blue == '0)
    else $error("dropped pixel carries nonzero sums");

endmodule

bind yuyv_to_rgb_accumulate_core yuvacc_checker u_yuvacc_checker (.*);

>>> bench/tb_yuyv_to_rgb_accumulate_core.sv
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb_accumulate_core
// Self-checking bench for the packed 4:2:2 to RGB accumulate core: a short
// stimulus table, then random macropixels under random frame settings.
// Every result word is checked against a local color and accumulation
// predictor.
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb_accumulate_core;
  import yuvacc_pkg::*;

  localparam int RUN_LIMIT = 12_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEGMENTS = 10;
  localparam int SEG_WORDS = 95;
  localparam longint FRAME_CAP = 64'd1 << POS_W;
  // unused register index, written once to confirm it has no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [31:0]          bytes;    // byte_zero in the top byte
    logic                 fs;
    bit                   gold_on;
    logic [47:0]          gold;     // r,g,b of first pixel, then second
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 pix_valid;
  logic                 pix_ready;
  logic [7:0]           byte_zero;
  logic [7:0]           byte_one;
  logic [7:0]           byte_two;
  logic [7:0]           byte_three;
  logic                 frame_start;
  logic                 res_valid;
  logic                 res_ready;
  logic [INDEX_W-1:0]   pixel_index;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [OUT_SUM_W-1:0] sum_red;
  logic [OUT_SUM_W-1:0] sum_green;
  logic [OUT_SUM_W-1:0] sum_blue;
  logic                 end_of_frame;
  logic                 dropped;
  logic                 last_of_pair;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // typed-in colors ride along with the input word
  bit          gold_on;
  logic [47:0] gold_rgb;

  // predictor state
  logic             pal_mode = 1'b0;
  logic [CFG_W-1:0] frame_w = DEF_WIDTH;
  logic [CFG_W-1:0] frame_h = DEF_HEIGHT;
  logic [POS_W-1:0] pix_pos = '0;
  bit [SUM_WIDTH-1:0] acc_red   [MAX_PIXELS];
  bit [SUM_WIDTH-1:0] acc_green [MAX_PIXELS];
  bit [SUM_WIDTH-1:0] acc_blue  [MAX_PIXELS];

  res_t      pending_pixels[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  int        stall_left = 0;

  yuyv_to_rgb_accumulate_core uut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready),
    .byte_zero(byte_zero), .byte_one(byte_one),
    .byte_two(byte_two), .byte_three(byte_three),
    .frame_start(frame_start),
    .res_valid(res_valid), .res_ready(res_ready),
    .pixel_index(pixel_index), .red(red), .green(green), .blue(blue),
    .sum_red(sum_red), .sum_green(sum_green), .sum_blue(sum_blue),
    .end_of_frame(end_of_frame), .dropped(dropped), .last_of_pair(last_of_pair),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    if (r == 2) return 8'($urandom_range(124, 132));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2048;
      3: return 12'd1;
      4: return 12'd2;
      default: begin
        if (r < 15) return 12'($urandom_range(1, 8));
        return 12'($urandom_range(0, 4095));
      end
    endcase
  endfunction

  function automatic plan_row_t mpx(input logic [31:0] bytes, input logic fs);
    plan_row_t p;
    p = '0;
    p.bytes = bytes;
    p.fs = fs;
    return p;
  endfunction

  function automatic plan_row_t mpx_gold(input logic [31:0] bytes, input logic fs,
                                         input logic [47:0] g);
    plan_row_t p;
    p = mpx(bytes, fs);
    p.gold_on = 1'b1;
    p.gold = g;
    return p;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_reg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  // floor shift by 8, clip to a byte
  function automatic logic [7:0] clamp_byte(input int acc);
    int s;
    if (acc < 0) return 8'd0;
    s = acc >>> 8;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // color one pixel, add it into its sum entry, advance the raster position
  task automatic shade_pixel(input logic [7:0] luma, input logic [7:0] uu,
                             input logic [7:0] vv, input bit second, output res_t r);
    int ys, cu, cv;
    longint fsize;
    bit eof;
    ys = int'(luma) * 256;
    cu = int'(uu) - 128;
    cv = int'(vv) - 128;
    r.red   = clamp_byte(ys + 359 * cv);
    r.green = clamp_byte(ys - 88 * cu - 183 * cv);
    r.blue  = clamp_byte(ys + 454 * cu);
    fsize = longint'(frame_w) * longint'(frame_h);
    if (fsize > FRAME_CAP) fsize = FRAME_CAP;
    eof = (longint'(pix_pos) + 1 >= fsize);
    r.pixel_index = pix_pos[INDEX_W-1:0];
    if (pix_pos < MAX_PIXELS) begin
      acc_red[pix_pos[ADDR_W-1:0]]   = acc_red[pix_pos[ADDR_W-1:0]] + SUM_WIDTH'(r.red);
      acc_green[pix_pos[ADDR_W-1:0]] = acc_green[pix_pos[ADDR_W-1:0]] + SUM_WIDTH'(r.green);
      acc_blue[pix_pos[ADDR_W-1:0]]  = acc_blue[pix_pos[ADDR_W-1:0]] + SUM_WIDTH'(r.blue);
      r.sum_red   = acc_red[pix_pos[ADDR_W-1:0]];
      r.sum_green = acc_green[pix_pos[ADDR_W-1:0]];
      r.sum_blue  = acc_blue[pix_pos[ADDR_W-1:0]];
      r.dropped = 1'b0;
    end else begin
      r.sum_red = '0;
      r.sum_green = '0;
      r.sum_blue = '0;
      r.dropped = 1'b1;
    end
    r.end_of_frame = eof;
    r.last_of_pair = second;
    pix_pos = eof ? '0 : pix_pos + 1'b1;
  endtask

  task automatic predict_word(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic fs, input bit g_on, input logic [47:0] g);
    logic [7:0] y0, y1, uu, vv;
    res_t r;
    int k;
    if (fs) pix_pos = '0;
    if (pal_mode) begin
      uu = b0; y0 = b1; vv = b2; y1 = b3;
    end else begin
      y0 = b0; uu = b1; y1 = b2; vv = b3;
    end
    for (k = 0; k < 2; k++) begin
      shade_pixel((k == 0) ? y0 : y1, uu, vv, k == 1, r);
      if (g_on) begin
        r.red   = g[47 - 24 * k -: 8];
        r.green = g[39 - 24 * k -: 8];
        r.blue  = g[31 - 24 * k -: 8];
      end
      pending_pixels.push_back(r);
    end
  endtask

  task automatic cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // track configuration, predict accepted words, check result words
  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PALETTE: pal_mode = cfg_data[0];
          REG_WIDTH:   frame_w = cfg_data;
          REG_HEIGHT:  frame_h = cfg_data;
          default: ;
        endcase
      end
      if (pix_valid && pix_ready)
        predict_word(byte_zero, byte_one, byte_two, byte_three, frame_start,
                     gold_on, gold_rgb);
      if (res_valid && res_ready) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, expected none got index %0d",
                   $time, pixel_index);
        end else begin
          e = pending_pixels.pop_front();
          cmp("pixel_index", 32'(e.pixel_index), 32'(pixel_index));
          cmp("red", 32'(e.red), 32'(red));
          cmp("green", 32'(e.green), 32'(green));
          cmp("blue", 32'(e.blue), 32'(blue));
          cmp("sum_red", e.sum_red, sum_red);
          cmp("sum_green", e.sum_green, sum_green);
          cmp("sum_blue", e.sum_blue, sum_blue);
          cmp("end_of_frame", 32'(e.end_of_frame), 32'(end_of_frame));
          cmp("dropped", 32'(e.dropped), 32'(dropped));
          cmp("last_of_pair", 32'(e.last_of_pair), 32'(last_of_pair));
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (quiet) begin
      res_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      res_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_word(input logic [31:0] bytes, input logic fs, input bit g_on,
                           input logic [47:0] g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    {byte_zero, byte_one, byte_two, byte_three} <= bytes;
    frame_start <= fs;
    gold_on <= g_on;
    gold_rgb <= g;
    do @(posedge clk); while (!pix_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every expected word is out and the pipe is empty
  task automatic drain();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n, seg;
    rst = 1'b1;
    pix_valid = 1'b0;
    byte_zero = '0;
    byte_one = '0;
    byte_two = '0;
    byte_three = '0;
    frame_start = 1'b0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gold_on = 1'b0;
    gold_rgb = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default frame, byte order Y0 U Y1 V; neutral chroma gives gray
    plan.push_back(mpx_gold(32'h00800080, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}));
    plan.push_back(mpx_gold(32'hFF80FF80, 1'b0,
                            {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}));
    plan.push_back(mpx_gold(32'h00000000, 1'b0, {8'd0, 8'd135, 8'd0, 8'd0, 8'd135, 8'd0}));
    plan.push_back(mpx_gold(32'hFFFFFFFF, 1'b0,
                            {8'd255, 8'd120, 8'd255, 8'd255, 8'd120, 8'd255}));
    plan.push_back(mpx(32'h00FF0000, 1'b0));
    plan.push_back(mpx(32'hFF00FFFF, 1'b0));
    // red just below zero before the shift
    plan.push_back(mpx(32'h0180017F, 1'b0));
    plan.push_back(mpx_gold(32'h10802080, 1'b1,
                            {8'd16, 8'd16, 8'd16, 8'd32, 8'd32, 8'd32}));
    plan.push_back(reg_row(REG_SPARE, 12'hFFF));
    plan.push_back(reg_row(REG_PALETTE, 12'd1));
    plan.push_back(mpx_gold(32'h804D80C8, 1'b0,
                            {8'd77, 8'd77, 8'd77, 8'd200, 8'd200, 8'd200}));
    plan.push_back(mpx(32'h00FFFF00, 1'b0));
    plan.push_back(mpx(32'hFF0000FF, 1'b0));
    plan.push_back(reg_row(REG_PALETTE, 12'd0));
    // shrink the frame below the current position
    plan.push_back(reg_row(REG_WIDTH, 12'd2));
    plan.push_back(reg_row(REG_HEIGHT, 12'd1));
    plan.push_back(mpx(32'h3C5A7896, 1'b0));
    plan.push_back(mpx(32'hC8329664, 1'b0));
    // zero width: every pixel ends the frame
    plan.push_back(reg_row(REG_WIDTH, 12'd0));
    plan.push_back(mpx(32'h20406080, 1'b0));
    plan.push_back(mpx(32'hA0C0E0F0, 1'b0));
    // odd width: macropixels straddle lines
    plan.push_back(reg_row(REG_WIDTH, 12'd3));
    plan.push_back(reg_row(REG_HEIGHT, 12'd3));
    for (n = 0; n < 5; n++) plan.push_back(mpx(32'h11223344 * (n + 1), 1'b0));
    plan.push_back(reg_row(REG_WIDTH, 12'd2048));
    plan.push_back(reg_row(REG_HEIGHT, 12'd2048));
    plan.push_back(mpx(32'h7F807F80, 1'b1));
    // frame size saturates
    plan.push_back(reg_row(REG_WIDTH, 12'd4095));
    plan.push_back(reg_row(REG_HEIGHT, 12'd4095));
    plan.push_back(mpx(32'h01FE01FE, 1'b0));

    foreach (plan[r]) begin
      if (plan[r].is_reg) begin
        drain();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        send_word(plan[r].bytes, plan[r].fs, plan[r].gold_on, plan[r].gold);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      quiet = 1'b0;
      drain();
      write_reg(REG_PALETTE, 12'($urandom_range(0, 1)));
      write_reg(REG_WIDTH, pick_dim());
      write_reg(REG_HEIGHT, pick_dim());
      quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < SEG_WORDS; n++)
        send_word({rand_byte(), rand_byte(), rand_byte(), rand_byte()},
                  $urandom_range(0, 19) == 0, 1'b0, '0);
    end

    quiet = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("yuyv_to_rgb_accumulate_core: match");
    end else begin
      $display("yuyv_to_rgb_accumulate_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("yuyv_to_rgb_accumulate_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/yuvacc_pkg.sv
rtl/core/yuvacc_ram.sv
rtl/core/yuvacc_seq.sv
rtl/core/yuvacc_color.sv
rtl/core/yuvacc_accum.sv
rtl/core/yuyv_to_rgb_accumulate_core.sv
rtl/core/yuvacc_checker.sv
bench/tb_yuyv_to_rgb_accumulate_core.sv
